// ----- sv/asts_pkg.sv -----
// Package for the ANSI SGR text styler: byte codes, phase and style types,
// command and status bundles, and the style helper functions.
// No dependencies; every other file of the block imports it.
package asts_pkg;

  // Byte codes that the escape sequence parser recognises.
  localparam logic [7:0] ESC_BYTE    = 8'h1b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_M        = 8'h6d;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  // SGR parameter codes.
  localparam logic [6:0] SGR_RESET      = 7'd0;
  localparam logic [6:0] SGR_BOLD       = 7'd1;
  localparam logic [6:0] SGR_BOLD_OFF   = 7'd22;
  localparam logic [6:0] SGR_FG_DEFAULT = 7'd39;
  localparam logic [6:0] SGR_FG_LO      = 7'd30;
  localparam logic [6:0] SGR_FG_HI      = 7'd37;
  localparam logic [6:0] SGR_BRIGHT_LO  = 7'd90;
  localparam logic [6:0] SGR_BRIGHT_HI  = 7'd97;
  localparam logic [6:0] PARAM_SAT      = 7'd127;

  // Colour codes held in the style registers (0 is the default colour).
  localparam logic [3:0] COL_RED     = 4'd2;
  localparam logic [3:0] COL_GREEN   = 4'd3;
  localparam logic [3:0] COL_YELLOW  = 4'd4;
  localparam logic [3:0] COL_BLUE    = 4'd5;
  localparam logic [3:0] COL_MAGENTA = 4'd6;
  localparam logic [3:0] COL_CYAN    = 4'd7;
  localparam logic [3:0] COL_WHITE   = 4'd8;

  // Output style codes.
  localparam logic [3:0] STY_RED     = 4'd2;
  localparam logic [3:0] STY_GREEN   = 4'd4;
  localparam logic [3:0] STY_YELLOW  = 4'd6;
  localparam logic [3:0] STY_BLUE    = 4'd8;
  localparam logic [3:0] STY_MAGENTA = 4'd10;
  localparam logic [3:0] STY_CYAN    = 4'd11;
  localparam logic [3:0] STY_WHITE   = 4'd12;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_ESC   = 2'd1,
    PH_PARAM = 2'd2
  } phase_t;

  // Bold flag and colour code together.
  typedef struct packed {
    logic       bold;
    logic [3:0] color;
  } sgr_attr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;      // handle the accepted byte normally
    logic capture;   // hold the accepted byte that broke a sequence
    logic rd;        // read the next held sequence byte
    logic emit_raw;  // present the byte just read as a result
    logic afresh;    // handle the held byte as plain text
  } asts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic brk;       // the byte on the input breaks the open sequence
    logic out_free;  // the output register can take a result this cycle
    logic last_raw;  // the read pointer is on the final held byte
    logic held_esc;  // the held byte is ESC
  } asts_stat_t;

  // Apply one SGR code to the style being built.
  function automatic sgr_attr_t sgr_apply(logic [6:0] code, sgr_attr_t cur);
    sgr_attr_t r;
    r = cur;
    if (code == SGR_RESET) begin
      r.bold  = 1'b0;
      r.color = 4'd0;
    end else if (code == SGR_BOLD) begin
      r.bold = 1'b1;
    end else if (code == SGR_BOLD_OFF) begin
      r.bold = 1'b0;
    end else if (code == SGR_FG_DEFAULT) begin
      r.color = 4'd0;
    end else if (code inside {[SGR_FG_LO:SGR_FG_HI]}) begin
      r.color = 4'(code - 7'd29);
    end else if (code inside {[SGR_BRIGHT_LO:SGR_BRIGHT_HI]}) begin
      r.color = 4'(code - 7'd89);
    end
    return r;
  endfunction

  // Map bold and colour to the display style code (bold is ignored for magenta and cyan).
  function automatic logic [3:0] style_of(sgr_attr_t a);
    logic [3:0] b;
    logic [3:0] s;
    b = {3'd0, a.bold};
    case (a.color)
      COL_RED:     s = STY_RED + b;
      COL_GREEN:   s = STY_GREEN + b;
      COL_YELLOW:  s = STY_YELLOW + b;
      COL_BLUE:    s = STY_BLUE + b;
      COL_MAGENTA: s = STY_MAGENTA;
      COL_CYAN:    s = STY_CYAN;
      COL_WHITE:   s = STY_WHITE + b;
      default:     s = b;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/asts_ctrl.sv -----
// Controller of the ANSI SGR text styler: sequences acceptance, replay of
// broken sequences and the fresh handling of the byte that broke them.
// Depends on asts_pkg.
module asts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  asts_pkg::asts_stat_t stat,
  output asts_pkg::asts_cmd_t  cmd
);
  import asts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EMIT   = 4'b0100,
    S_AFRESH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  // Input is taken only when a possible result has somewhere to go.
  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign in_fire  = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (stat.brk) begin
            cmd.capture = 1'b1;
            state_next  = S_READ;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_raw = 1'b1;
          state_next   = stat.last_raw ? S_AFRESH : S_READ;
        end
      end
      S_AFRESH: begin
        if (stat.held_esc || stat.out_free) begin
          cmd.afresh = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/asts_dp.sv -----
// Datapath of the ANSI SGR text styler: style and parameter registers,
// the raw sequence store and the output register.
// Depends on asts_pkg; driven by asts_ctrl through the command bundle.
module asts_dp #(
  parameter int MAX_SEQ_BYTES = 32,
  parameter int MAX_PARAMS    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  asts_pkg::asts_cmd_t  cmd,
  output asts_pkg::asts_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           text_byte,
  output logic [3:0]           style,
  output logic                 last_of_run
);
  import asts_pkg::*;

  localparam int LEN_W  = $clog2(MAX_SEQ_BYTES + 1);
  localparam int IDX_W  = $clog2(MAX_SEQ_BYTES);
  localparam int PCNT_W = $clog2(MAX_PARAMS + 1);

  // Parser and style state.
  phase_t              phase;
  sgr_attr_t           committed;
  sgr_attr_t           shadow;
  logic [6:0]          param_value;
  logic                digit_seen;
  logic [PCNT_W-1:0]   param_count;
  logic [LEN_W-1:0]    raw_length;

  // Replay state.
  logic [7:0]          held_byte;
  logic [IDX_W-1:0]    rd_idx;
  logic [7:0]          rd_data;

  // Sequence store.
  logic [7:0]          raw_mem [MAX_SEQ_BYTES];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [7:0]          mem_wdata;

  // Byte classification.
  logic                is_digit;
  logic                is_semi;
  logic                room;
  logic                take_param;
  logic [7:0]          digit_sub;
  logic [10:0]         acc;
  logic [6:0]          acc_sat;
  sgr_attr_t           applied;
  logic                out_load;
  logic [7:0]          out_byte_next;
  logic                out_last_next;

  assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_semi    = (in_byte == CH_SEMI);
  assign room       = (param_count < PCNT_W'(MAX_PARAMS)) &&
                      (raw_length < LEN_W'(MAX_SEQ_BYTES));
  assign take_param = room && (is_digit || is_semi);

  // Decimal accumulation with saturation.
  assign digit_sub = in_byte - CH_ZERO;
  assign acc       = 11'(param_value) * 11'd10 + 11'(digit_sub[3:0]);
  assign acc_sat   = (acc > 11'(PARAM_SAT)) ? PARAM_SAT : acc[6:0];

  // The pending parameter applied to the style being built.
  assign applied = sgr_apply(digit_seen ? param_value : SGR_RESET, shadow);

  // Status to the controller.
  always_comb begin
    stat          = '0;
    stat.out_free = !out_valid || out_ready;
    stat.held_esc = (held_byte == ESC_BYTE);
    stat.last_raw = ((LEN_W'(rd_idx) + LEN_W'(1)) == raw_length);
    case (phase)
      PH_ESC:   stat.brk = (in_byte != CH_LBRACKET);
      PH_PARAM: stat.brk = (in_byte != CH_M) && !take_param;
      default:  stat.brk = 1'b0;
    endcase
  end

  // Store write port: the opening ESC goes to the first entry, later
  // sequence bytes go after those already held.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = in_byte;
    if (cmd.step) begin
      case (phase)
        PH_TEXT:  mem_we = (in_byte == ESC_BYTE);
        PH_ESC:   mem_we = 1'b1;
        PH_PARAM: mem_we = (in_byte != CH_M);
        default:  mem_we = 1'b0;
      endcase
      if (phase != PH_TEXT) begin
        mem_waddr = raw_length[IDX_W-1:0];
      end
    end else if (cmd.afresh) begin
      mem_we    = stat.held_esc;
      mem_wdata = held_byte;
    end
  end

  // Memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      raw_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_data <= raw_mem[rd_idx];
    end
  end

  // Result selection.
  always_comb begin
    out_load      = 1'b0;
    out_byte_next = in_byte;
    out_last_next = 1'b1;
    if (cmd.step && (phase == PH_TEXT) && (in_byte != ESC_BYTE)) begin
      out_load = 1'b1;
    end else if (cmd.emit_raw) begin
      out_load      = 1'b1;
      out_byte_next = rd_data;
      out_last_next = stat.last_raw && stat.held_esc;
    end else if (cmd.afresh && !stat.held_esc) begin
      out_load      = 1'b1;
      out_byte_next = held_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      text_byte   <= out_byte_next;
      style       <= style_of(committed);
      last_of_run <= out_last_next;
    end
  end

  // Replay pointer and held byte.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held_byte <= in_byte;
      rd_idx    <= '0;
    end else if (cmd.emit_raw) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // Parser and style registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TEXT;
      committed   <= '0;
      shadow      <= '0;
      param_value <= '0;
      digit_seen  <= 1'b0;
      param_count <= '0;
      raw_length  <= '0;
    end else if (cmd.step) begin
      case (phase)
        PH_TEXT: begin
          if (in_byte == ESC_BYTE) begin
            raw_length <= LEN_W'(1);
            phase      <= PH_ESC;
          end
        end
        PH_ESC: begin
          raw_length  <= LEN_W'(2);
          phase       <= PH_PARAM;
          shadow      <= committed;
          param_value <= '0;
          digit_seen  <= 1'b0;
          param_count <= '0;
        end
        PH_PARAM: begin
          if (in_byte == CH_M) begin
            // Terminator: the pending parameter counts if it has digits or
            // is the only one.
            if (digit_seen || (param_count == '0)) begin
              committed <= applied;
              shadow    <= applied;
            end else begin
              committed <= shadow;
            end
            raw_length <= '0;
            phase      <= PH_TEXT;
          end else begin
            if (is_digit) begin
              param_value <= acc_sat;
              digit_seen  <= 1'b1;
            end else begin
              shadow      <= applied;
              param_count <= param_count + PCNT_W'(1);
              param_value <= '0;
              digit_seen  <= 1'b0;
            end
            raw_length <= raw_length + LEN_W'(1);
          end
        end
        default: begin
          phase <= PH_TEXT;
        end
      endcase
    end else if (cmd.afresh) begin
      // Replay is over; the held byte starts from plain text.
      if (stat.held_esc) begin
        raw_length <= LEN_W'(1);
        phase      <= PH_ESC;
      end else begin
        raw_length <= '0;
        phase      <= PH_TEXT;
      end
    end
  end

endmodule

// ----- sv/ansi_sgr_text_styler.sv -----
// ANSI SGR text styler, top level. The result of an accepted plain byte appears
// in the output register on the next cycle; sequence bytes give no result. A
// broken sequence is replayed through the store's one registered read port:
// each held byte is read, then emitted once the output register is free.
// Reset (synchronous, active high) clears style, parser and output valid;
// the sequence store is not cleared.
module ansi_sgr_text_styler #(
  parameter int MAX_SEQ_BYTES = 32,
  parameter int MAX_PARAMS    = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] text_byte,
  output logic [3:0] style,
  output logic       last_of_run
);
  import asts_pkg::*;

  asts_cmd_t  cmd;
  asts_stat_t stat;

  // Controller.
  asts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  asts_dp #(
    .MAX_SEQ_BYTES (MAX_SEQ_BYTES),
    .MAX_PARAMS    (MAX_PARAMS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .text_byte   (text_byte),
    .style       (style),
    .last_of_run (last_of_run)
  );

  // A transaction that breaks a sequence stalls the input for the replay.
  a_break_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && stat.brk) |=> !in_ready)
    else $error("input accepted during replay");

  // A replayed byte is only presented when the output register can take it.
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_raw |-> stat.out_free)
    else $error("replayed byte would overwrite a pending result");

  // A replayed byte before a plain breaking byte never closes the run.
  a_replay_not_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_raw && !stat.held_esc) |=> (out_valid && !last_of_run))
    else $error("replayed byte marked as final result");

endmodule
